// File: design/xtea_pkg.sv
package xtea_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_KEYS   = 4;
  localparam int KEY_SEL_W  = $clog2(NUM_KEYS);
  localparam int CFG_IDX_W  = 8;
  localparam int ROUNDS     = 32;
  localparam int HALF_STEPS = 2 * ROUNDS;
  localparam int SHIFT_L    = 4;
  localparam int SHIFT_R    = 5;
  localparam int SEL_SHIFT  = 11;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_SEL_W-1:0] key_sel_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_set_t;

  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } dir_t;

  // One pipeline stage's contents.
  typedef struct packed {
    logic  valid;
    dir_t  dir;
    word_t y;
    word_t z;
  } stage_t;

  // Constants that set one half-round of the unrolled schedule.
  typedef struct packed {
    logic     odd;
    word_t    enc_sum;
    word_t    dec_sum;
    key_sel_t enc_sel;
    key_sel_t dec_sel;
  } step_cfg_t;

  function automatic word_t delta_times(input int n);
    word_t n_w;
    n_w = word_t'(n);
    return word_t'(DELTA * n_w);
  endfunction

  function automatic step_cfg_t step_consts(input int s);
    step_cfg_t c;
    int        r;
    r = s >> 1;
    c.odd = ((s & 1) != 0);
    if (c.odd) begin
      c.enc_sum = delta_times(r + 1);
      c.dec_sum = delta_times(ROUNDS - r - 1);
      c.enc_sel = key_sel_t'(c.enc_sum >> SEL_SHIFT);
      c.dec_sel = key_sel_t'(c.dec_sum);
    end else begin
      c.enc_sum = delta_times(r);
      c.dec_sum = delta_times(ROUNDS - r);
      c.enc_sel = key_sel_t'(c.enc_sum);
      c.dec_sel = key_sel_t'(c.dec_sum >> SEL_SHIFT);
    end
    return c;
  endfunction

endpackage

// File: design/xtea_in_if.sv
interface xtea_in_if import xtea_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  kind;
  word_t first_word;
  word_t second_word;

  modport source (output valid, output kind, output first_word, output second_word,
                  input ready);
  modport sink (input valid, input kind, input first_word, input second_word,
                output ready);
endinterface

// File: design/xtea_out_if.sv
interface xtea_out_if import xtea_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t out_first_word;
  word_t out_second_word;

  modport source (output valid, output out_first_word, output out_second_word,
                  input ready);
  modport sink (input valid, input out_first_word, input out_second_word,
                output ready);
endinterface

// File: design/xtea_cfg_if.sv
interface xtea_cfg_if import xtea_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/xtea_half_round.sv
module xtea_half_round import xtea_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  step_cfg_t step_cfg,
  input  key_set_t  keys,
  input  stage_t    stage_in,
  output stage_t    stage_out
);

  logic     valid_r;
  dir_t     dir_r;
  word_t    y_r;
  word_t    z_r;
  stage_t   stage_nxt;
  logic     upd_first;
  word_t    src;
  word_t    dst;
  word_t    sum;
  key_sel_t sel;
  word_t    mix;
  word_t    res;

  // Encryption updates the first word on even half-rounds, decryption on odd ones.
  assign upd_first = (step_cfg.odd == (stage_in.dir == DIR_DECRYPT));

  always_comb begin
    src = upd_first ? stage_in.z : stage_in.y;
    dst = upd_first ? stage_in.y : stage_in.z;
    if (stage_in.dir == DIR_DECRYPT) begin
      sum = step_cfg.dec_sum;
      sel = step_cfg.dec_sel;
    end else begin
      sum = step_cfg.enc_sum;
      sel = step_cfg.enc_sel;
    end
    mix = (((src << SHIFT_L) ^ (src >> SHIFT_R)) + src) ^ (sum + keys[sel]);
    res = (stage_in.dir == DIR_DECRYPT) ? (dst - mix) : (dst + mix);
    stage_nxt       = stage_in;
    stage_nxt.y     = upd_first ? res : stage_in.y;
    stage_nxt.z     = upd_first ? stage_in.z : res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_r <= stage_nxt.dir;
      y_r   <= stage_nxt.y;
      z_r   <= stage_nxt.z;
    end
  end

  assign stage_out = '{valid: valid_r, dir: dir_r, y: y_r, z: z_r};

endmodule

// File: design/xtea_block_cipher.sv
// XTEA block cipher, one 64-bit block per item, fully unrolled.
// The in_ch channel carries the direction (kind: 0 encrypt, 1 decrypt) and the
// two 32-bit halves of a block. The out_ch channel returns the processed halves.
// The cfg_ch channel writes the four 32-bit key words at indexes 0 to 3; writes
// to other indexes are dropped. cfg_ch is always ready, and keys should only be
// changed while no item is in flight.
// Each of the 64 Feistel half-rounds is one register stage, and a new item can be
// accepted every cycle unless a result waits on a stalled out_ch. The last stage
// register is the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ch.ready drops until out_ch takes the item; nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears the key words to zero.
module xtea_block_cipher import xtea_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  xtea_in_if.sink    in_ch,
  xtea_out_if.source out_ch,
  xtea_cfg_if.sink   cfg_ch
);

  key_set_t keys_r;
  logic     adv;
  stage_t   stages [HALF_STEPS+1];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else if (cfg_ch.valid && (cfg_ch.index < cfg_idx_t'(NUM_KEYS))) begin
      keys_r[cfg_ch.index[KEY_SEL_W-1:0]] <= cfg_ch.data;
    end
  end

  assign adv         = !stages[HALF_STEPS].valid || out_ch.ready;
  assign in_ch.ready = adv;

  assign stages[0] = '{valid: in_ch.valid, dir: dir_t'(in_ch.kind),
                       y: in_ch.first_word, z: in_ch.second_word};

  for (genvar s = 0; s < HALF_STEPS; s++) begin : g_step
    localparam step_cfg_t StepCfg = step_consts(s);

    xtea_half_round u_half_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .step_cfg  (StepCfg),
      .keys      (keys_r),
      .stage_in  (stages[s]),
      .stage_out (stages[s+1])
    );
  end

  assign out_ch.valid           = stages[HALF_STEPS].valid;
  assign out_ch.out_first_word  = stages[HALF_STEPS].y;
  assign out_ch.out_second_word = stages[HALF_STEPS].z;

endmodule

// File: test/tb_xtea_block_cipher.sv
module tb_xtea_block_cipher import xtea_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = HALF_STEPS + 8;
  localparam int PHASE_ITEMS = 165;
  localparam int NUM_PHASES  = 8;

  // Keeps its own copy of the key words, computes the cipher output for every
  // accepted item and checks the results against it in order.
  class cipher_predictor;
    word_t key_words[NUM_KEYS] = '{default: '0};
    word_t pending_first[$];
    word_t pending_second[$];
    int    errors;

    function void write_key(cfg_idx_t idx, word_t val);
      if (idx < NUM_KEYS) begin
        key_words[key_sel_t'(idx)] = val;
      end
    endfunction

    function word_t mix_word(word_t v, word_t sum, word_t k);
      return (((v << SHIFT_L) ^ (v >> SHIFT_R)) + v) ^ (sum + k);
    endfunction

    function void note_block(dir_t dir, word_t y_in, word_t z_in);
      word_t y;
      word_t z;
      word_t sum;
      y = y_in;
      z = z_in;
      if (dir == DIR_ENCRYPT) begin
        sum = '0;
        for (int r = 0; r < ROUNDS; r++) begin
          y += mix_word(z, sum, key_words[key_sel_t'(sum)]);
          sum += DELTA;
          z += mix_word(y, sum, key_words[key_sel_t'(sum >> SEL_SHIFT)]);
        end
      end else begin
        sum = word_t'(DELTA * word_t'(ROUNDS));
        for (int r = 0; r < ROUNDS; r++) begin
          z -= mix_word(y, sum, key_words[key_sel_t'(sum >> SEL_SHIFT)]);
          sum -= DELTA;
          y -= mix_word(z, sum, key_words[key_sel_t'(sum)]);
        end
      end
      pending_first.push_back(y);
      pending_second.push_back(z);
    endfunction

    function void check_block(word_t y, word_t z);
      word_t exp_y;
      word_t exp_z;
      if (pending_first.size() == 0) begin
        $error("unexpected item: out_first_word %h, out_second_word %h", y, z);
        errors++;
        return;
      end
      exp_y = pending_first.pop_front();
      exp_z = pending_second.pop_front();
      if (y !== exp_y) begin
        $error("out_first_word: expected %h, actual %h", exp_y, y);
        errors++;
      end
      if (z !== exp_z) begin
        $error("out_second_word: expected %h, actual %h", exp_z, z);
        errors++;
      end
    endfunction

    function int pending();
      return pending_first.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  xtea_in_if  in_ch();
  xtea_out_if out_ch();
  xtea_cfg_if cfg_ch();

  xtea_block_cipher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cipher_predictor book = new();

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        book.note_block(dir_t'(in_ch.kind), in_ch.first_word, in_ch.second_word);
      end
      if (out_ch.valid && out_ch.ready) begin
        book.check_block(out_ch.out_first_word, out_ch.out_second_word);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        book.write_key(cfg_ch.index, cfg_ch.data);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // The receiver stalls at random; on request it holds off for a long stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(WORD_W - 1);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send_block(dir_t dir, word_t y, word_t z);
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= dir;
    in_ch.first_word  <= y;
    in_ch.second_word <= z;
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, word_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Writes all four key words plus one write to an index past the key words,
  // which must be dropped.
  task automatic program_keys(word_t k0, word_t k1, word_t k2, word_t k3);
    write_reg(cfg_idx_t'(0), k0);
    write_reg(cfg_idx_t'(1), k1);
    write_reg(cfg_idx_t'($urandom_range(NUM_KEYS, (1 << CFG_IDX_W) - 1)), pick_word());
    write_reg(cfg_idx_t'(2), k2);
    write_reg(cfg_idx_t'(3), k3);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_corners();
    word_t corner_words[6];
    corner_words = '{32'h0000_0000, 32'hffff_ffff, 32'haaaa_aaaa,
                     32'h5555_5555, 32'h0000_0001, 32'h8000_0000};
    for (int i = 0; i < 6; i++) begin
      send_block(DIR_ENCRYPT, corner_words[i], corner_words[5 - i]);
      send_block(DIR_DECRYPT, corner_words[i], corner_words[5 - i]);
    end
  endtask

  initial begin
    int sender_idle[4];
    int receiver_stall[4];
    sender_idle    = '{0, 62, 0, 25};
    receiver_stall = '{0, 0, 62, 25};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    quiet_cycles   = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= DIR_ENCRYPT;
    in_ch.first_word  <= '0;
    in_ch.second_word <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Keys at their reset value of zero, then all ones.
    send_corners();
    drain();
    program_keys('1, '1, '1, '1);
    send_corners();
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = sender_idle[ph % 4];
      recv_stall_pct = receiver_stall[ph % 4];
      program_keys(pick_word(), pick_word(), pick_word(), pick_word());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 60) begin
          hold_req = 1'b1;
        end
        send_block(dir_t'($urandom_range(1)), pick_word(), pick_word());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/xtea_pkg.sv
design/xtea_in_if.sv
design/xtea_out_if.sv
design/xtea_cfg_if.sv
design/xtea_half_round.sv
design/xtea_block_cipher.sv
test/tb_xtea_block_cipher.sv
